// File: rtl/core/fir_iq_pkg.sv
// Shared constants, state codes and control types of the I/Q FIR filter.
package fir_iq_pkg;

   localparam int MAX_TAPS_DEF     = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF   = 16;

   localparam int ACC_WIDTH       = 64;
   localparam int TAP_COUNT_WIDTH = 7;
   localparam int SHIFT_WIDTH     = 5;
   localparam int TAP_INDEX_WIDTH = 6;
   localparam int CSR_DATA_WIDTH  = 7;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET    = 7'd64;
   localparam logic [SHIFT_WIDTH-1:0]     OUTPUT_SHIFT_RESET = 5'd15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAP_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_SHIFT = 1'b1;

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_WRITE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_OUTPUT
   } fsm_state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

endpackage

// File: rtl/core/fir_iq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fir_iq_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/fir_iq_mac.sv
// Registered multiply stage and wrapping accumulators for the I and Q paths.
module fir_iq_mac #(
   parameter int SAMPLE_WIDTH = fir_iq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = fir_iq_pkg::COEF_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fir_iq_pkg::mac_ctrl_type           ctrl,
   input  logic signed [COEF_WIDTH-1:0]       coef,
   input  logic signed [SAMPLE_WIDTH-1:0]     samp_i,
   input  logic signed [SAMPLE_WIDTH-1:0]     samp_q,
   output logic [fir_iq_pkg::ACC_WIDTH-1:0]   acc_i,
   output logic [fir_iq_pkg::ACC_WIDTH-1:0]   acc_q,
   output logic                               busy
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W  = fir_iq_pkg::ACC_WIDTH;

   logic signed [PROD_W-1:0] prod_i_ff;
   logic signed [PROD_W-1:0] prod_q_ff;
   logic                     mul_valid_ff;
   logic                     mul_valid_in;
   logic [ACC_W-1:0]         acc_i_ff;
   logic [ACC_W-1:0]         acc_i_in;
   logic [ACC_W-1:0]         acc_q_ff;
   logic [ACC_W-1:0]         acc_q_in;

   assign mul_valid_in = ctrl.valid & ~ctrl.clear;

   always_ff @(posedge clock) begin
      prod_i_ff <= PROD_W'(coef) * PROD_W'(samp_i);
      prod_q_ff <= PROD_W'(coef) * PROD_W'(samp_q);
   end

   always_comb begin
      acc_i_in = acc_i_ff;
      acc_q_in = acc_q_ff;
      if (ctrl.clear) begin
         acc_i_in = '0;
         acc_q_in = '0;
      end else if (mul_valid_ff) begin
         acc_i_in = acc_i_ff + ACC_W'(prod_i_ff);
         acc_q_in = acc_q_ff + ACC_W'(prod_q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_i_ff     <= '0;
         acc_q_ff     <= '0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         acc_i_ff     <= acc_i_in;
         acc_q_ff     <= acc_q_in;
      end
   end

   assign acc_i = acc_i_ff;
   assign acc_q = acc_q_ff;
   assign busy  = mul_valid_ff;

endmodule

// File: rtl/core/fir_iq_scale.sv
// Three-stage round, arithmetic shift and saturate of both accumulators.
module fir_iq_scale #(
   parameter int SAMPLE_WIDTH = fir_iq_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fir_iq_pkg::SHIFT_WIDTH-1:0]   shift,
   input  logic [fir_iq_pkg::ACC_WIDTH-1:0]     acc_i,
   input  logic [fir_iq_pkg::ACC_WIDTH-1:0]     acc_q,
   output logic                                 done,
   output logic [SAMPLE_WIDTH-1:0]              out_i,
   output logic [SAMPLE_WIDTH-1:0]              out_q,
   output logic                                 saturated
);

   localparam int ACC_W = fir_iq_pkg::ACC_WIDTH;
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic [SAMPLE_WIDTH-1:0] OUT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] OUT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic [fir_iq_pkg::SHIFT_WIDTH-1:0] shift_ff;
   logic [ACC_W-1:0]         round_bias;
   logic [ACC_W-1:0]         rnd_i_ff;
   logic [ACC_W-1:0]         rnd_q_ff;
   logic signed [ACC_W-1:0]  shr_i_ff;
   logic signed [ACC_W-1:0]  shr_q_ff;
   logic [SAMPLE_WIDTH-1:0]  out_i_ff;
   logic [SAMPLE_WIDTH-1:0]  out_q_ff;
   logic                     sat_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic                     v3_ff;
   logic [SAMPLE_WIDTH-1:0]  clip_i;
   logic [SAMPLE_WIDTH-1:0]  clip_q;
   logic                     hit_i;
   logic                     hit_q;

   // half an output LSB; no rounding at a shift of zero
   always_comb begin
      if (shift == '0) begin
         round_bias = '0;
      end else begin
         round_bias = ACC_W'(1) << (shift - 1'b1);
      end
   end

   always_comb begin
      hit_i = 1'b1;
      hit_q = 1'b1;
      if (shr_i_ff > SAT_HI) begin
         clip_i = OUT_HI;
      end else if (shr_i_ff < SAT_LO) begin
         clip_i = OUT_LO;
      end else begin
         clip_i = shr_i_ff[SAMPLE_WIDTH-1:0];
         hit_i  = 1'b0;
      end
      if (shr_q_ff > SAT_HI) begin
         clip_q = OUT_HI;
      end else if (shr_q_ff < SAT_LO) begin
         clip_q = OUT_LO;
      end else begin
         clip_q = shr_q_ff[SAMPLE_WIDTH-1:0];
         hit_q  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= shift;
         rnd_i_ff <= acc_i + round_bias;
         rnd_q_ff <= acc_q + round_bias;
      end
      if (v1_ff) begin
         shr_i_ff <= $signed(rnd_i_ff) >>> shift_ff;
         shr_q_ff <= $signed(rnd_q_ff) >>> shift_ff;
      end
      if (v2_ff) begin
         out_i_ff <= clip_i;
         out_q_ff <= clip_q;
         sat_ff   <= hit_i | hit_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign done      = v3_ff;
   assign out_i     = out_i_ff;
   assign out_q     = out_q_ff;
   assign saturated = sat_ff;

endmodule

// File: rtl/core/fir_filter_iq_core.sv
// Top level of the I/Q FIR filter: sequencer, history and coefficient RAMs.
//
//  channel | ports               | direction | handshake
//  --------+---------------------+-----------+---------------------------
//  req     | action, samples,tap | in        | req_valid / req_ready
//  rsp     | out_i, out_q, sat   | out       | rsp_valid / rsp_ready
//  csr     | index, write data   | in        | csr_write_en, no wait
//
// A filter transaction accepts the request, issues one RAM read per tap in use, drains
// the read and multiply stages, adds the rounding bias, shifts, saturates, flags done
// and loads the response register. A coefficient write goes into the coefficient RAM
// on acceptance. After reset a clearing pass over all MAX_TAPS addresses zeroes both
// RAMs with req_ready low. The response register holds while rsp_ready is low;
// a new request is taken meanwhile, and its result waits until the slot frees.
module fir_filter_iq_core #(
   parameter int MAX_TAPS     = fir_iq_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_iq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = fir_iq_pkg::COEF_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [fir_iq_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fir_iq_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample_q,
   input  logic [fir_iq_pkg::TAP_INDEX_WIDTH-1:0]  req_tap_index,
   input  logic signed [COEF_WIDTH-1:0]            req_tap_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_out_q,
   output logic                                    rsp_saturated
);

   localparam int ADDR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W   = $clog2(MAX_TAPS + 1);
   localparam int TC_W    = fir_iq_pkg::TAP_COUNT_WIDTH;
   localparam int CMP_W   = (CNT_W > TC_W) ? CNT_W : TC_W;
   localparam int TI_W    = fir_iq_pkg::TAP_INDEX_WIDTH;
   localparam int IDX_CW  = (CNT_W > TI_W) ? CNT_W : TI_W;
   localparam int HIST_W  = 2 * SAMPLE_WIDTH;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);

   // configuration registers
   logic [TC_W-1:0]                     tap_count_ff;
   logic [fir_iq_pkg::SHIFT_WIDTH-1:0]  output_shift_ff;

   fir_iq_pkg::fsm_state_type state_ff;
   fir_iq_pkg::fsm_state_type state_in;

   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] clr_cnt_in;
   logic [ADDR_W-1:0] wp_ff;
   logic [ADDR_W-1:0] wp_in;
   logic [ADDR_W-1:0] rd_ptr_ff;
   logic [ADDR_W-1:0] rd_ptr_in;
   logic [ADDR_W-1:0] k_ff;
   logic [ADDR_W-1:0] k_in;
   logic              rd_valid_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_i_ff;
   logic [SAMPLE_WIDTH-1:0]  rsp_q_ff;
   logic                     rsp_sat_ff;

   logic [CNT_W-1:0]  taps_eff;
   logic [CMP_W-1:0]  taps_cmp;
   logic              accept;
   logic              accept_filter;
   logic              accept_write;
   logic              idx_ok;
   logic              last_tap;
   logic              drained;

   // sequencer outputs
   logic                      hist_we;
   logic                      coef_we;
   logic                      rd_issue;
   logic                      scale_start;
   logic                      rsp_load;
   fir_iq_pkg::mac_ctrl_type  mac_ctrl;

   logic [ADDR_W-1:0]     hist_waddr;
   logic [HIST_W-1:0]     hist_wdata;
   logic [HIST_W-1:0]     hist_rdata;
   logic [ADDR_W-1:0]     coef_waddr;
   logic [COEF_WIDTH-1:0] coef_wdata;
   logic [COEF_WIDTH-1:0] coef_rdata;

   logic [fir_iq_pkg::ACC_WIDTH-1:0] acc_i;
   logic [fir_iq_pkg::ACC_WIDTH-1:0] acc_q;
   logic                             mac_busy;
   logic                             scale_done;
   logic [SAMPLE_WIDTH-1:0]          scale_i;
   logic [SAMPLE_WIDTH-1:0]          scale_q;
   logic                             scale_sat;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff    <= fir_iq_pkg::TAP_COUNT_RESET;
         output_shift_ff <= fir_iq_pkg::OUTPUT_SHIFT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            fir_iq_pkg::CSR_TAP_COUNT: begin
               tap_count_ff <= csr_write_data[TC_W-1:0];
            end
            fir_iq_pkg::CSR_OUTPUT_SHIFT: begin
               output_shift_ff <= csr_write_data[fir_iq_pkg::SHIFT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp tap count to the built maximum
   always_comb begin
      taps_cmp = CMP_W'(tap_count_ff);
      if (taps_cmp > CMP_W'(MAX_TAPS)) begin
         taps_eff = CNT_W'(MAX_TAPS);
      end else begin
         taps_eff = CNT_W'(taps_cmp);
      end
   end

   assign accept        = req_valid & req_ready;
   assign accept_filter = accept & (req_action == fir_iq_pkg::ACTION_FILTER);
   assign accept_write  = accept & (req_action == fir_iq_pkg::ACTION_WRITE);
   assign idx_ok        = IDX_CW'(req_tap_index) < IDX_CW'(MAX_TAPS);
   assign last_tap      = (CNT_W'(k_ff) + CNT_W'(1)) == taps_eff;
   assign drained       = ~rd_valid_ff & ~mac_busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fir_iq_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = fir_iq_pkg::ST_IDLE;
            end
         end
         fir_iq_pkg::ST_IDLE: begin
            if (accept_filter) begin
               state_in = (taps_eff == '0) ? fir_iq_pkg::ST_DRAIN : fir_iq_pkg::ST_RUN;
            end
         end
         fir_iq_pkg::ST_RUN: begin
            if (last_tap) begin
               state_in = fir_iq_pkg::ST_DRAIN;
            end
         end
         fir_iq_pkg::ST_DRAIN: begin
            if (drained) begin
               state_in = fir_iq_pkg::ST_SCALE;
            end
         end
         fir_iq_pkg::ST_SCALE: begin
            if (scale_done) begin
               state_in = fir_iq_pkg::ST_OUTPUT;
            end
         end
         fir_iq_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = fir_iq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fir_iq_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      hist_we        = 1'b0;
      coef_we        = 1'b0;
      rd_issue       = 1'b0;
      scale_start    = 1'b0;
      rsp_load       = 1'b0;
      mac_ctrl.clear = 1'b0;
      mac_ctrl.valid = 1'b0;
      unique case (state_ff)
         fir_iq_pkg::ST_CLEAR: begin
            hist_we = 1'b1;
            coef_we = 1'b1;
         end
         fir_iq_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            hist_we        = accept_filter;
            coef_we        = accept_write & idx_ok;
            mac_ctrl.clear = accept_filter;
         end
         fir_iq_pkg::ST_RUN: begin
            rd_issue = 1'b1;
         end
         fir_iq_pkg::ST_DRAIN: begin
            scale_start = drained;
         end
         fir_iq_pkg::ST_SCALE: begin
         end
         fir_iq_pkg::ST_OUTPUT: begin
            rsp_load = ~rsp_valid_ff | rsp_ready;
         end
         default: begin
         end
      endcase
      // read data of the previous cycle feeds the multiplier
      mac_ctrl.valid = rd_valid_ff;
   end

   // pointers and counters
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      wp_in      = wp_ff;
      rd_ptr_in  = rd_ptr_ff;
      k_in       = k_ff;
      if (state_ff == fir_iq_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (accept_filter) begin
         // newest sample sits at wp; older ones walk backward from there
         rd_ptr_in = wp_ff;
         k_in      = '0;
         wp_in     = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
      end else if (rd_issue) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - 1'b1;
         k_in      = k_ff + 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_iq_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         rd_ptr_ff    <= '0;
         k_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         rd_ptr_ff    <= rd_ptr_in;
         k_ff         <= k_in;
         rd_valid_ff  <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_i_ff   <= scale_i;
         rsp_q_ff   <= scale_q;
         rsp_sat_ff <= scale_sat;
      end
   end

   // RAM write ports: clearing pass or accepted transaction
   always_comb begin
      if (state_ff == fir_iq_pkg::ST_CLEAR) begin
         hist_waddr = clr_cnt_ff;
         hist_wdata = '0;
         coef_waddr = clr_cnt_ff;
         coef_wdata = '0;
      end else begin
         hist_waddr = wp_ff;
         hist_wdata = {req_sample_q, req_sample_i};
         coef_waddr = ADDR_W'(req_tap_index);
         coef_wdata = req_tap_value;
      end
   end

   fir_iq_ram #(
      .WIDTH  (HIST_W),
      .DEPTH  (MAX_TAPS),
      .ADDR_W (ADDR_W)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (rd_ptr_ff),
      .rdata (hist_rdata)
   );

   fir_iq_ram #(
      .WIDTH  (COEF_WIDTH),
      .DEPTH  (MAX_TAPS),
      .ADDR_W (ADDR_W)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (k_ff),
      .rdata (coef_rdata)
   );

   fir_iq_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (coef_rdata),
      .samp_i (hist_rdata[SAMPLE_WIDTH-1:0]),
      .samp_q (hist_rdata[HIST_W-1:SAMPLE_WIDTH]),
      .acc_i  (acc_i),
      .acc_q  (acc_q),
      .busy   (mac_busy)
   );

   fir_iq_scale #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .shift     (output_shift_ff),
      .acc_i     (acc_i),
      .acc_q     (acc_q),
      .done      (scale_done),
      .out_i     (scale_i),
      .out_q     (scale_q),
      .saturated (scale_sat)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_i     = rsp_i_ff;
   assign rsp_out_q     = rsp_q_ff;
   assign rsp_saturated = rsp_sat_ff;

   // nothing may be in flight in the MAC pipeline when a request can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fir_iq_pkg::ST_IDLE) |-> (!rd_valid_ff && !mac_busy))
      else $error("MAC pipeline busy while idle");

   // the scaler finishes only while the sequencer waits for it
   a_scale_done: assert property (@(posedge clock) disable iff (reset)
      scale_done |-> (state_ff == fir_iq_pkg::ST_SCALE))
      else $error("scale result outside scale state");

   // history is never rewritten while taps are being read
   a_hist_stable: assert property (@(posedge clock) disable iff (reset)
      hist_we |-> (state_ff != fir_iq_pkg::ST_RUN && state_ff != fir_iq_pkg::ST_DRAIN))
      else $error("history written during accumulation");

   // a response is loaded only into a free or draining slot
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

endmodule

// File: bench/tb_fir_filter_iq_core.sv
// Self-checking testbench for the I/Q FIR filter core: random traffic against a filter predictor.
`timescale 1ns / 1ps

typedef logic signed [fir_iq_pkg::SAMPLE_WIDTH_DEF-1:0] iq_sample_type;
typedef logic signed [fir_iq_pkg::COEF_WIDTH_DEF-1:0]   tap_coef_type;

typedef struct packed {
   iq_sample_type out_i;
   iq_sample_type out_q;
   logic          saturated;
} fir_output_type;

class fir_iq_scoreboard;
   localparam int TAPS = fir_iq_pkg::MAX_TAPS_DEF;
   localparam int SW   = fir_iq_pkg::SAMPLE_WIDTH_DEF;

   int unsigned    tap_count;
   int unsigned    output_shift;
   tap_coef_type   coef_store [TAPS];
   iq_sample_type  history_i [TAPS-1];
   iq_sample_type  history_q [TAPS-1];
   fir_output_type expected_outputs [$];
   int unsigned    errors;
   bit             clip_seen;

   function new();
      tap_count    = fir_iq_pkg::TAP_COUNT_RESET;
      output_shift = fir_iq_pkg::OUTPUT_SHIFT_RESET;
      foreach (coef_store[k]) coef_store[k] = '0;
      foreach (history_i[k]) begin
         history_i[k] = '0;
         history_q[k] = '0;
      end
      errors = 0;
   endfunction

   function void set_register(logic [fir_iq_pkg::CSR_INDEX_WIDTH-1:0] index,
                              int unsigned value);
      if (index == fir_iq_pkg::CSR_TAP_COUNT)
         tap_count = value & 32'h7f;
      else
         output_shift = value & 32'h1f;
   endfunction

   function int unsigned pending();
      return expected_outputs.size();
   endfunction

   // Round half up by the output shift, then clip to the sample range.
   function iq_sample_type round_saturate(longint acc);
      longint r;
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SW - 1)) - 1;
      lo = -hi - 1;
      r = acc;
      if (output_shift != 0)
         r = (r + (longint'(1) <<< (output_shift - 1))) >>> output_shift;
      if (r > hi) begin
         clip_seen = 1'b1;
         r = hi;
      end else if (r < lo) begin
         clip_seen = 1'b1;
         r = lo;
      end
      return iq_sample_type'(r);
   endfunction

   function void note_request(logic action, iq_sample_type si, iq_sample_type sq,
                              logic [fir_iq_pkg::TAP_INDEX_WIDTH-1:0] index,
                              tap_coef_type value);
      longint         acc_i;
      longint         acc_q;
      longint         xi;
      longint         xq;
      int unsigned    n;
      int             k;
      fir_output_type res;
      if (action == fir_iq_pkg::ACTION_WRITE) begin
         if (index < TAPS)
            coef_store[index] = value;
         return;
      end
      n = (tap_count > TAPS) ? TAPS : tap_count;
      acc_i = 0;
      acc_q = 0;
      for (k = 0; k < n; k++) begin
         if (k == 0) begin
            xi = longint'(si);
            xq = longint'(sq);
         end else begin
            xi = longint'(history_i[k-1]);
            xq = longint'(history_q[k-1]);
         end
         acc_i += longint'(coef_store[k]) * xi;
         acc_q += longint'(coef_store[k]) * xq;
      end
      for (k = TAPS - 2; k > 0; k--) begin
         history_i[k] = history_i[k-1];
         history_q[k] = history_q[k-1];
      end
      history_i[0] = si;
      history_q[0] = sq;
      clip_seen = 1'b0;
      res.out_i = round_saturate(acc_i);
      res.out_q = round_saturate(acc_q);
      res.saturated = clip_seen;
      expected_outputs.insert(expected_outputs.size(), res);
   endfunction

   function void check_response(iq_sample_type out_i, iq_sample_type out_q, logic saturated);
      fir_output_type exp_out;
      if (expected_outputs.size() == 0) begin
         $error("unexpected response transaction: out_i %0d out_q %0d saturated %0b",
                out_i, out_q, saturated);
         errors++;
         return;
      end
      exp_out = expected_outputs.pop_front();
      if (out_i !== exp_out.out_i) begin
         $error("out_i mismatch: expected %0d, actual %0d", exp_out.out_i, out_i);
         errors++;
      end
      if (out_q !== exp_out.out_q) begin
         $error("out_q mismatch: expected %0d, actual %0d", exp_out.out_q, out_q);
         errors++;
      end
      if (saturated !== exp_out.saturated) begin
         $error("saturated mismatch: expected %0b, actual %0b", exp_out.saturated, saturated);
         errors++;
      end
   endfunction
endclass

module tb_fir_filter_iq_core;

   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int PRESSURE_PHASE  = 3;
   localparam int PRESSURE_CYCLES = 600;
   localparam int SETTLE_CYCLES   = 200;

   localparam iq_sample_type SAMPLE_MAX = 16'sh7fff;
   localparam iq_sample_type SAMPLE_MIN = 16'sh8000;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   csr_write_en = 1'b0;
   logic [fir_iq_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [fir_iq_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic                                   req_action = fir_iq_pkg::ACTION_FILTER;
   iq_sample_type                          req_sample_i = '0;
   iq_sample_type                          req_sample_q = '0;
   logic [fir_iq_pkg::TAP_INDEX_WIDTH-1:0] req_tap_index = '0;
   tap_coef_type                           req_tap_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   iq_sample_type                          rsp_out_i;
   iq_sample_type                          rsp_out_q;
   logic                                   rsp_saturated;

   fir_iq_scoreboard sb;
   bit sender_idle_on   = 1'b1;
   bit receiver_idle_on = 1'b1;
   bit hold_rsp_req     = 1'b0;

   int unsigned phase_taps  [NUM_PHASES] = '{1, 0, 127, 64, 2, 17, 64, 40, 8, 63};
   int unsigned phase_shift [NUM_PHASES] = '{0, 15, 127, 15, 1, 16, 0, 18, 14, 31};

   fir_filter_iq_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .req_tap_index  (req_tap_index),
      .req_tap_value  (req_tap_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_i      (rsp_out_i),
      .rsp_out_q      (rsp_out_q),
      .rsp_saturated  (rsp_saturated)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap(bit enabled);
      int unsigned r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic program_registers(input int unsigned count, input int unsigned shamt);
      csr_write_en   <= 1'b1;
      csr_index      <= fir_iq_pkg::CSR_TAP_COUNT;
      csr_write_data <= fir_iq_pkg::CSR_DATA_WIDTH'(count);
      @(posedge clock);
      sb.set_register(fir_iq_pkg::CSR_TAP_COUNT, count);
      csr_index      <= fir_iq_pkg::CSR_OUTPUT_SHIFT;
      csr_write_data <= fir_iq_pkg::CSR_DATA_WIDTH'(shamt);
      @(posedge clock);
      sb.set_register(fir_iq_pkg::CSR_OUTPUT_SHIFT, shamt);
      csr_write_en   <= 1'b0;
   endtask

   task automatic send_request(input logic action, input iq_sample_type si,
                               input iq_sample_type sq,
                               input logic [fir_iq_pkg::TAP_INDEX_WIDTH-1:0] index,
                               input tap_coef_type value);
      int unsigned gap;
      gap = pick_gap(sender_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_sample_i  <= si;
      req_sample_q  <= sq;
      req_tap_index <= index;
      req_tap_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(action, si, sq, index, value);
   endtask

   task automatic random_request();
      logic action;
      action = ($urandom_range(0, 3) == 0) ? fir_iq_pkg::ACTION_WRITE
                                           : fir_iq_pkg::ACTION_FILTER;
      send_request(action, rand_word(), rand_word(),
                   fir_iq_pkg::TAP_INDEX_WIDTH'($urandom), rand_word());
   endtask

   // Wait out outstanding results, then let a trailing coefficient write retire.
   task automatic drain_results();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int p;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // hold off until the clearing pass is done
      do @(posedge clock); while (!req_ready);
      program_registers(64, 15);

      send_request(fir_iq_pkg::ACTION_FILTER, SAMPLE_MAX, SAMPLE_MIN, '0, '0);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd0, SAMPLE_MIN);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd63, SAMPLE_MAX);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd1, SAMPLE_MAX);
      send_request(fir_iq_pkg::ACTION_FILTER, SAMPLE_MIN, SAMPLE_MIN, '0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, SAMPLE_MAX, '0, '0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, '0, SAMPLE_MAX, '0, '0);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd2, 16'sd1);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd3, -16'sd1);
      send_request(fir_iq_pkg::ACTION_FILTER, 16'sd1, -16'sd1, '0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, SAMPLE_MIN, SAMPLE_MAX, '0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, '0, '0, 6'h3f, 16'shffff);
      send_request(fir_iq_pkg::ACTION_FILTER, SAMPLE_MAX, SAMPLE_MAX, '0, '0);
      send_request(fir_iq_pkg::ACTION_WRITE, '0, '0, 6'd0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, -16'sd1, 16'sd1, '0, '0);
      send_request(fir_iq_pkg::ACTION_FILTER, 16'sh4000, '0, '0, '0);
      req_valid <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         program_registers(phase_taps[p], phase_shift[p]);
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         if (p == PRESSURE_PHASE)
            hold_rsp_req = 1'b1;
         repeat (ITEMS_PER_PHASE) random_request();
         req_valid <= 1'b0;
      end

      drain_results();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("fir_filter_iq_core test passed");
      else
         $display("fir_filter_iq_core test failed");
      $finish;
   end

   initial begin : response_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            // long back-pressure: let the core fill up and stall its input
            hold_rsp_req = 1'b0;
            stall = PRESSURE_CYCLES;
         end else begin
            stall = pick_gap(receiver_idle_on);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_out_i, rsp_out_q, rsp_saturated);
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("fir_filter_iq_core test failed");
      $finish;
   end

endmodule

// File: fir_filter_iq_core.f
rtl/core/fir_iq_pkg.sv
rtl/core/fir_iq_ram.sv
rtl/core/fir_iq_mac.sv
rtl/core/fir_iq_scale.sv
rtl/core/fir_filter_iq_core.sv
bench/tb_fir_filter_iq_core.sv
